>>> sv/rle_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the run-length unpacker with escape.
// No dependencies; used by rle_unpack_with_escape_core.
package rle_pkg;

    localparam int unsigned MAX_RESULTS = 8;
    localparam int unsigned RUN_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;
    localparam logic [7:0] ESC_BYTE   = 8'h5C;

    // parse modes
    localparam logic [2:0] MODE_BEGIN  = 3'd0;
    localparam logic [2:0] MODE_SYMBOL = 3'd1;
    localparam logic [2:0] MODE_NUMBER = 3'd2;
    localparam logic [2:0] MODE_ESCAPE = 3'd3;
    localparam logic [2:0] MODE_FAILED = 3'd4;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_DIGIT = 2'd1,
        ST_TRAIL_ESC = 2'd2
    } t_status;

    // one decoded request waiting to be expanded
    typedef struct packed {
        logic [RUN_W-1:0] reps;      // character results still to send
        logic [7:0]       chr;
        logic             tail;      // a non-character result follows the run
        t_status          tail_st;
        logic             done;      // request carried end of string
    } t_job;

endpackage

>>> sv/rle_unpack_with_escape_core.sv
`timescale 1ns / 1ps
// Latency: a request's first result is shown in the cycle after it is accepted.
// Throughput: one result per cycle while i_stall is low; a request that causes n results (up to 8)
// stalls the input until its last result is taken, set by the single result register and its run counter.
// Requests that cause no result are absorbed without occupying the result register.
// Reset (synchronous, active low) clears the parse state, drops any pending results
// and stalls the input while it is held. Depends on rle_pkg.
module rle_unpack_with_escape_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_string,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_char_valid,
    output logic [1:0] o_status,
    output logic       o_last_of_run,
    output logic       o_string_done
);

    localparam int unsigned RW = rle_pkg::RUN_W;

    logic [2:0]        r_mode, n_mode;
    logic [7:0]        r_held, n_held;
    logic [1:0]        r_fail, n_fail;
    logic              r_busy, n_busy;
    rle_pkg::t_job     r_job,  n_job;
    rle_pkg::t_job     dec;

    logic [2:0]        mode_eff;
    logic              is_digit, is_esc, accept, take, cur_last, finish;
    logic [3:0]        dval;

    // ---------------- decode of one request ----------------
    always_comb begin
        is_digit = (i_in_byte >= rle_pkg::DIGIT_ZERO) && (i_in_byte <= rle_pkg::DIGIT_NINE);
        is_esc   = (i_in_byte == rle_pkg::ESC_BYTE);
        dval     = i_in_byte[3:0];
        mode_eff = (r_mode > rle_pkg::MODE_FAILED) ? rle_pkg::MODE_BEGIN : r_mode;

        n_mode       = mode_eff;
        n_held       = r_held;
        n_fail       = r_fail;
        dec.reps     = '0;
        dec.chr      = i_in_byte;
        dec.tail     = 1'b0;
        dec.tail_st  = rle_pkg::ST_OK;
        dec.done     = i_end_of_string;

        case (mode_eff)
            rle_pkg::MODE_FAILED: begin
            end
            rle_pkg::MODE_SYMBOL: begin
                if (is_digit) begin
                    // repeat the held character digit-minus-one more times
                    dec.chr  = r_held;
                    dec.reps = (dval > 4'd1) ? RW'(dval - 4'd1) : '0;
                    n_mode   = rle_pkg::MODE_NUMBER;
                end else if (is_esc) begin
                    n_mode = rle_pkg::MODE_ESCAPE;
                end else begin
                    dec.reps = RW'(1);
                    n_held   = i_in_byte;
                end
            end
            rle_pkg::MODE_ESCAPE: begin
                dec.reps = RW'(1);
                n_held   = i_in_byte;
                n_mode   = rle_pkg::MODE_SYMBOL;
            end
            default: begin
                if (is_digit) begin
                    dec.tail    = 1'b1;
                    dec.tail_st = rle_pkg::ST_BAD_DIGIT;
                    n_fail      = 2'(rle_pkg::ST_BAD_DIGIT);
                    n_mode      = rle_pkg::MODE_FAILED;
                end else if (is_esc) begin
                    n_mode = rle_pkg::MODE_ESCAPE;
                end else begin
                    dec.reps = RW'(1);
                    n_held   = i_in_byte;
                    n_mode   = rle_pkg::MODE_SYMBOL;
                end
            end
        endcase

        if (i_end_of_string) begin
            if (n_mode == rle_pkg::MODE_ESCAPE) begin
                dec.tail    = 1'b1;
                dec.tail_st = rle_pkg::ST_TRAIL_ESC;
            end else if ((dec.reps == '0) && !dec.tail) begin
                // silent end or failed string: report the stored status
                dec.tail    = 1'b1;
                dec.tail_st = rle_pkg::t_status'(r_fail);
            end
            n_mode = rle_pkg::MODE_BEGIN;
            n_held = '0;
            n_fail = '0;
        end
    end

    // ---------------- result register ----------------
    always_comb begin
        cur_last = (r_job.reps == '0) || ((r_job.reps == RW'(1)) && !r_job.tail);
        take     = r_busy && !i_stall;
        finish   = take && cur_last;
        o_stall  = !i_rst_n || (r_busy && !finish);
        accept   = i_valid && !o_stall;

        o_valid       = r_busy;
        o_char_valid  = (r_job.reps != '0);
        o_out_char    = o_char_valid ? r_job.chr : 8'd0;
        o_status      = o_char_valid ? 2'(rle_pkg::ST_OK) : 2'(r_job.tail_st);
        o_last_of_run = cur_last;
        o_string_done = cur_last && r_job.done;

        n_busy = r_busy;
        n_job  = r_job;
        if (take) begin
            if (cur_last) begin
                n_busy = 1'b0;
            end else if (r_job.reps != '0) begin
                n_job.reps = r_job.reps - RW'(1);
            end
        end
        if (accept && ((dec.reps != '0) || dec.tail)) begin
            n_busy = 1'b1;
            n_job  = dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= rle_pkg::MODE_BEGIN;
            r_held <= '0;
            r_fail <= '0;
            r_busy <= 1'b0;
        end else begin
            if (accept) begin
                r_mode <= n_mode;
                r_held <= n_held;
                r_fail <= n_fail;
            end
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

`ifndef ASSERT_OFF
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_job.reps <= RW'(rle_pkg::MAX_RESULTS)))
        else $error("run counter above limit");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_string_done) |-> o_last_of_run)
        else $error("string_done without last_of_run");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_of_run) |=> o_valid)
        else $error("run dropped before its last result");

    a_accept_only_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && o_valid) |-> (!i_stall && o_last_of_run))
        else $error("request accepted over a pending run");

    a_no_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_char_valid) |-> (o_out_char == 8'd0))
        else $error("non-character result carries a character");
`endif

endmodule
